// ===== rtl/decision_stump_search_defines.svh =====
// Assertion macros for the decision stump search block.
// Included by the top level; no other dependencies.
`ifndef DECISION_STUMP_SEARCH_DEFINES_SVH
`define DECISION_STUMP_SEARCH_DEFINES_SVH

// cons must hold in the same cycle as ante
`define DSS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define DSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dss_pkg.sv =====
// Shared types and constants for the decision stump search block.
// No dependencies.
`timescale 1ns / 1ps

package dss_pkg;

  localparam int unsigned MAX_EXAMPLES_DEF = 1024;
  localparam int unsigned WEIGHT_BITS_DEF  = 16;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned IDX_OUT_W  = 11;
  localparam int unsigned CNT_OUT_W  = 11;
  localparam int unsigned WSUM_OUT_W = 26;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PREP,
    ST_SCAN,
    ST_DRAIN
  } dss_state_e;

  typedef struct packed {
    logic clear;
    logic rd_valid;
  } scan_ctrl_t;

  typedef struct packed {
    logic pipe_busy;
    logic found;
  } scan_stat_t;

endpackage

// ===== rtl/decision_stump_search.sv =====
// Decision stump search, top level: example loading, scan sequencing, result strobe.
// Depends on dss_pkg, dss_example_mem, dss_scan_pipe and the assertion macro header.
//
// Examples load one per cycle while busy is low; a transfer happens when start is high
// and busy is low. The transfer that carries last_example_i raises busy and starts a
// scan that reads the example store once, one entry per cycle through its single read
// port; busy stays high until the scan pipeline has drained. The result then appears
// for exactly one cycle with result_valid_o, in the cycle busy falls; the receiver
// cannot stall it, so it must take it then. Examples beyond MAX_EXAMPLES are dropped.
`timescale 1ns / 1ps
`include "decision_stump_search_defines.svh"

module decision_stump_search
  import dss_pkg::*;
#(
  parameter int unsigned MAX_EXAMPLES = MAX_EXAMPLES_DEF,
  parameter int unsigned WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  label_positive_i,
  input  logic [SAMPLE_W-1:0]   sample_weight_i,
  input  logic                  last_example_i,
  output logic                  result_valid_o,
  output logic                  stump_found_o,
  output logic [IDX_OUT_W-1:0]  split_index_o,
  output logic                  below_is_positive_o,
  output logic [CNT_OUT_W-1:0]  mistake_count_o,
  output logic [WSUM_OUT_W-1:0] weighted_mistakes_o
);

  localparam int unsigned CW  = $clog2(MAX_EXAMPLES + 1);
  localparam int unsigned AW  = $clog2(MAX_EXAMPLES);
  localparam int unsigned EWB = (WEIGHT_BITS < SAMPLE_W) ? WEIGHT_BITS : SAMPLE_W;
  localparam int unsigned SW  = EWB + CW;
  localparam int unsigned HW  = (SW > WEIGHT_BITS) ? SW : WEIGHT_BITS;
  localparam int unsigned DW  = EWB + 1;

  dss_state_e state_q, state_d;

  logic [CW-1:0] count_q, pos_q, rd_addr_q, rd_addr_d, rd_idx_q;
  logic [SW-1:0] wtotal_q, pos_w_q;
  logic          rd_valid_q;
  logic          result_valid_q, result_valid_d;

  logic           accept, store_ok, mem_we, mem_re, count_clr;
  logic [EWB-1:0] weight_in;
  logic [DW-1:0]  rdata;
  scan_ctrl_t     ctrl;
  scan_stat_t     stat;

  logic [CW-1:0] best_idx, best_cnt;
  logic          best_dir;
  logic [SW-1:0] best_w;

  assign busy      = (state_q != ST_LOAD);
  assign accept    = start && !busy;
  assign store_ok  = (count_q < CW'(MAX_EXAMPLES));
  assign mem_we    = accept && store_ok;
  assign weight_in = sample_weight_i[EWB-1:0];

  always_comb begin
    state_d        = state_q;
    rd_addr_d      = rd_addr_q;
    mem_re         = 1'b0;
    count_clr      = 1'b0;
    result_valid_d = 1'b0;
    ctrl.clear     = 1'b0;
    ctrl.rd_valid  = rd_valid_q;
    case (state_q)
      ST_LOAD: begin
        if (accept && last_example_i) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        ctrl.clear = 1'b1;
        rd_addr_d  = '0;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        if (rd_addr_q < count_q) begin
          mem_re    = 1'b1;
          rd_addr_d = rd_addr_q + CW'(1);
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid_q && !stat.pipe_busy) begin
          result_valid_d = 1'b1;
          count_clr      = 1'b1;
          state_d        = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_LOAD;
      rd_addr_q      <= '0;
      rd_idx_q       <= '0;
      rd_valid_q     <= 1'b0;
      result_valid_q <= 1'b0;
      count_q        <= '0;
      pos_q          <= '0;
      wtotal_q       <= '0;
      pos_w_q        <= '0;
    end else begin
      state_q        <= state_d;
      rd_addr_q      <= rd_addr_d;
      rd_idx_q       <= rd_addr_q;
      rd_valid_q     <= mem_re;
      result_valid_q <= result_valid_d;
      if (count_clr) begin
        count_q  <= '0;
        pos_q    <= '0;
        wtotal_q <= '0;
        pos_w_q  <= '0;
      end else if (mem_we) begin
        count_q  <= count_q + CW'(1);
        wtotal_q <= wtotal_q + SW'(weight_in);
        if (label_positive_i) begin
          pos_q   <= pos_q + CW'(1);
          pos_w_q <= pos_w_q + SW'(weight_in);
        end
      end
    end
  end

  dss_example_mem #(
    .DEPTH (MAX_EXAMPLES),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({label_positive_i, weight_in}),
    .re_i    (mem_re),
    .raddr_i (rd_addr_q[AW-1:0]),
    .rdata_o (rdata)
  );

  dss_scan_pipe #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .CW          (CW),
    .EWB         (EWB),
    .SW          (SW),
    .HW          (HW)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .rd_idx_i     (rd_idx_q),
    .rd_label_i   (rdata[DW-1]),
    .rd_weight_i  (rdata[EWB-1:0]),
    .n_i          (count_q),
    .pos_total_i  (pos_q),
    .wtotal_i     (wtotal_q),
    .pos_wtotal_i (pos_w_q),
    .stat_o       (stat),
    .best_idx_o   (best_idx),
    .best_dir_o   (best_dir),
    .best_cnt_o   (best_cnt),
    .best_w_o     (best_w)
  );

  assign result_valid_o      = result_valid_q;
  assign stump_found_o       = stat.found;
  assign split_index_o       = IDX_OUT_W'(best_idx);
  assign below_is_positive_o = best_dir;
  assign mistake_count_o     = CNT_OUT_W'(best_cnt);
  assign weighted_mistakes_o = WSUM_OUT_W'(best_w);

  `DSS_ASSERT_NEXT(a_last_starts_scan, clk_i, rst_ni, start && !busy && last_example_i, busy, "last example did not start the search")
  `DSS_ASSERT_SAME(a_no_write_in_scan, clk_i, rst_ni, mem_we, state_q == ST_LOAD, "example store written outside loading")
  `DSS_ASSERT_NEXT(a_single_result, clk_i, rst_ni, result_valid_o, !result_valid_o, "result strobe held longer than one cycle")

endmodule

// ===== rtl/dss_example_mem.sv =====
// Example store: one write port, one read port, registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module dss_example_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 17
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dss_scan_pipe.sv =====
// Threshold scan pipeline: left-side sums, rule scoring, best-stump tracking.
// Depends on dss_pkg.
`timescale 1ns / 1ps

module dss_scan_pipe
  import dss_pkg::*;
#(
  parameter int unsigned WEIGHT_BITS = 16,
  parameter int unsigned CW          = 11,
  parameter int unsigned EWB         = 16,
  parameter int unsigned SW          = 27,
  parameter int unsigned HW          = 27
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  scan_ctrl_t     ctrl_i,
  input  logic [CW-1:0]  rd_idx_i,
  input  logic           rd_label_i,
  input  logic [EWB-1:0] rd_weight_i,
  input  logic [CW-1:0]  n_i,
  input  logic [CW-1:0]  pos_total_i,
  input  logic [SW-1:0]  wtotal_i,
  input  logic [SW-1:0]  pos_wtotal_i,
  output scan_stat_t     stat_o,
  output logic [CW-1:0]  best_idx_o,
  output logic           best_dir_o,
  output logic [CW-1:0]  best_cnt_o,
  output logic [SW-1:0]  best_w_o
);

  localparam logic [HW-1:0] HALF = HW'(1) << (WEIGHT_BITS - 1);

  logic [CW-1:0]  neg_total_q;
  logic [SW-1:0]  wneg_total_q;
  logic           prev_label_q;
  logic [EWB-1:0] prev_w_q;
  logic [CW-1:0]  pos_l_q, neg_l_q;
  logic [SW-1:0]  wpos_l_q, wneg_l_q;

  logic           s1_v_q, s2_v_q, s3_v_q;
  logic [CW-1:0]  s1_idx_q, s2_idx_q, s3_idx_q;
  logic [CW-1:0]  s2_cnt_a_q, s2_cnt_b_q;
  logic [SW-1:0]  s2_w_a_q, s2_w_b_q;
  logic [CW-1:0]  s3_cnt_q;
  logic [SW-1:0]  s3_w_q;
  logic           s3_dir_q;

  logic           found_q;
  logic [CW-1:0]  best_idx_q, best_cnt_q;
  logic           best_dir_q;
  logic [SW-1:0]  best_w_q;

  logic           take;

  assign take = s3_v_q && (!found_q || ((s3_cnt_q < best_cnt_q) && (HW'(s3_w_q) < HALF)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_total_q  <= '0;
      wneg_total_q <= '0;
      prev_label_q <= 1'b0;
      prev_w_q     <= '0;
      pos_l_q      <= '0;
      neg_l_q      <= '0;
      wpos_l_q     <= '0;
      wneg_l_q     <= '0;
      s1_v_q       <= 1'b0;
      s2_v_q       <= 1'b0;
      s3_v_q       <= 1'b0;
      s1_idx_q     <= '0;
      s2_idx_q     <= '0;
      s3_idx_q     <= '0;
      s2_cnt_a_q   <= '0;
      s2_cnt_b_q   <= '0;
      s2_w_a_q     <= '0;
      s2_w_b_q     <= '0;
      s3_cnt_q     <= '0;
      s3_w_q       <= '0;
      s3_dir_q     <= 1'b0;
      found_q      <= 1'b0;
      best_idx_q   <= '0;
      best_cnt_q   <= '0;
      best_dir_q   <= 1'b0;
      best_w_q     <= '0;
    end else if (ctrl_i.clear) begin
      neg_total_q  <= n_i - pos_total_i;
      wneg_total_q <= wtotal_i - pos_wtotal_i;
      prev_label_q <= 1'b0;
      prev_w_q     <= '0;
      pos_l_q      <= '0;
      neg_l_q      <= '0;
      wpos_l_q     <= '0;
      wneg_l_q     <= '0;
      s1_v_q       <= 1'b0;
      s2_v_q       <= 1'b0;
      s3_v_q       <= 1'b0;
      found_q      <= 1'b0;
      best_idx_q   <= '0;
      best_cnt_q   <= '0;
      best_dir_q   <= 1'b0;
      best_w_q     <= '0;
    end else begin
      // stage 1: fold example k-1 into the left sums, flag a label change at k
      s1_v_q <= 1'b0;
      if (ctrl_i.rd_valid) begin
        prev_label_q <= rd_label_i;
        prev_w_q     <= rd_weight_i;
        s1_idx_q     <= rd_idx_i;
        if (rd_idx_i != '0) begin
          s1_v_q <= (rd_label_i != prev_label_q);
          if (prev_label_q) begin
            pos_l_q  <= pos_l_q + CW'(1);
            wpos_l_q <= wpos_l_q + SW'(prev_w_q);
          end else begin
            neg_l_q  <= neg_l_q + CW'(1);
            wneg_l_q <= wneg_l_q + SW'(prev_w_q);
          end
        end
      end
      // stage 2: score both rules
      s2_v_q     <= s1_v_q;
      s2_idx_q   <= s1_idx_q;
      s2_cnt_a_q <= neg_l_q + (pos_total_i - pos_l_q);
      s2_w_a_q   <= wneg_l_q + (pos_wtotal_i - wpos_l_q);
      s2_cnt_b_q <= pos_l_q + (neg_total_q - neg_l_q);
      s2_w_b_q   <= wpos_l_q + (wneg_total_q - wneg_l_q);
      // stage 3: pick the rule, below-positive wins a tie
      s3_v_q   <= s2_v_q;
      s3_idx_q <= s2_idx_q;
      if (s2_cnt_a_q <= s2_cnt_b_q) begin
        s3_cnt_q <= s2_cnt_a_q;
        s3_w_q   <= s2_w_a_q;
        s3_dir_q <= 1'b1;
      end else begin
        s3_cnt_q <= s2_cnt_b_q;
        s3_w_q   <= s2_w_b_q;
        s3_dir_q <= 1'b0;
      end
      // stage 4: best so far
      if (take) begin
        found_q    <= 1'b1;
        best_idx_q <= s3_idx_q;
        best_cnt_q <= s3_cnt_q;
        best_dir_q <= s3_dir_q;
        best_w_q   <= s3_w_q;
      end
    end
  end

  assign stat_o.pipe_busy = s1_v_q | s2_v_q | s3_v_q;
  assign stat_o.found     = found_q;
  assign best_idx_o       = best_idx_q;
  assign best_dir_o       = best_dir_q;
  assign best_cnt_o       = best_cnt_q;
  assign best_w_o         = best_w_q;

endmodule

// ===== tb/decision_stump_search_tb.sv =====
// Self-checking testbench for decision_stump_search: loads weighted, labeled example sets
// through the start/busy handshake and checks every result strobe against a stump predictor.
// Depends on dss_pkg and the decision_stump_search RTL.
`timescale 1ns / 1ps

module decision_stump_search_tb;
  import dss_pkg::*;

  localparam int unsigned CLK_HALF_NS    = 6;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned ITEM_TARGET    = 1950;
  localparam int unsigned BIG_SET_SIZE   = MAX_EXAMPLES_DEF + 6;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned TIMEOUT_CYCLES = 300_000;
  localparam int unsigned MAX_PRINTED    = 50;
  localparam int unsigned IDLE_PCT_FIRST  = 35;
  localparam int unsigned IDLE_PCT_SECOND = 51;
  localparam longint unsigned HALF_WEIGHT = 64'd1 << (WEIGHT_BITS_DEF - 1);

  typedef enum int {
    LBL_RANDOM,
    LBL_RUNS,
    LBL_ALTERNATE,
    LBL_CONSTANT,
    LBL_ONE_CHANGE
  } label_pattern_e;

  typedef enum int {
    WT_RANDOM,
    WT_SMALL,
    WT_EXTREME,
    WT_ZERO
  } weight_pattern_e;

  typedef struct packed {
    logic                label;
    logic [SAMPLE_W-1:0] weight;
    logic                last;
  } example_t;

  typedef struct packed {
    logic                  found;
    logic [IDX_OUT_W-1:0]  split;
    logic                  below_pos;
    logic [CNT_OUT_W-1:0]  mistakes;
    logic [WSUM_OUT_W-1:0] weighted;
  } stump_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  start          = 1'b0;
  logic                  label_positive = 1'b0;
  logic [SAMPLE_W-1:0]   sample_weight  = '0;
  logic                  last_example   = 1'b0;
  logic                  busy;
  logic                  result_valid;
  logic                  stump_found;
  logic [IDX_OUT_W-1:0]  split_index;
  logic                  below_is_positive;
  logic [CNT_OUT_W-1:0]  mistake_count;
  logic [WSUM_OUT_W-1:0] weighted_mistakes;

  example_t    pending_examples[$];
  stump_t      expected_stumps[$];
  example_t    next_example;
  stump_t      want;
  int unsigned total_items;
  int unsigned accepted_items;
  int unsigned idle_pct;
  int unsigned results_seen;
  int unsigned mismatches;

  // current set as the block should hold it
  logic                set_label [MAX_EXAMPLES_DEF];
  logic [SAMPLE_W-1:0] set_weight[MAX_EXAMPLES_DEF];
  int unsigned         set_count;
  int unsigned         set_pos_count;
  longint unsigned     set_pos_weight;

  decision_stump_search u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .label_positive_i   (label_positive),
    .sample_weight_i    (sample_weight),
    .last_example_i     (last_example),
    .result_valid_o     (result_valid),
    .stump_found_o      (stump_found),
    .split_index_o      (split_index),
    .below_is_positive_o(below_is_positive),
    .mistake_count_o    (mistake_count),
    .weighted_mistakes_o(weighted_mistakes)
  );

  always begin
    #CLK_HALF_NS clk_i = 1'b1;
    #CLK_HALF_NS clk_i = 1'b0;
  end

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic check_field(string name, longint unsigned got, longint unsigned exp_val);
    if (got != exp_val) begin
      report($sformatf("result %0d %s: got %0d, expected %0d", results_seen, name, got,
                       exp_val));
    end
  endtask

  function automatic stump_t search_stump();
    longint unsigned w_total, w_neg_total, w_pos_below, w_neg_below, w_a, w_b, w_pick;
    int unsigned     neg_total, pos_below, neg_below, cnt_a, cnt_b, cnt_pick, i;
    logic            dir_pick;
    stump_t          best;
    best        = '0;
    w_total     = 0;
    w_pos_below = 0;
    w_neg_below = 0;
    pos_below   = 0;
    neg_below   = 0;
    for (i = 0; i < set_count; i++) begin
      w_total += set_weight[i];
    end
    w_neg_total = w_total - set_pos_weight;
    neg_total   = set_count - set_pos_count;
    for (i = 1; i < set_count; i++) begin
      if (set_label[i-1]) begin
        pos_below++;
        w_pos_below += set_weight[i-1];
      end else begin
        neg_below++;
        w_neg_below += set_weight[i-1];
      end
      if (set_label[i] != set_label[i-1]) begin
        cnt_a = neg_below + (set_pos_count - pos_below);
        w_a   = w_neg_below + (set_pos_weight - w_pos_below);
        cnt_b = pos_below + (neg_total - neg_below);
        w_b   = w_pos_below + (w_neg_total - w_neg_below);
        if (cnt_a <= cnt_b) begin
          cnt_pick = cnt_a;
          w_pick   = w_a;
          dir_pick = 1'b1;
        end else begin
          cnt_pick = cnt_b;
          w_pick   = w_b;
          dir_pick = 1'b0;
        end
        if (!best.found || (cnt_pick < best.mistakes && w_pick < HALF_WEIGHT)) begin
          best.found     = 1'b1;
          best.split     = i[IDX_OUT_W-1:0];
          best.below_pos = dir_pick;
          best.mistakes  = cnt_pick[CNT_OUT_W-1:0];
          best.weighted  = w_pick[WSUM_OUT_W-1:0];
        end
      end
    end
    return best;
  endfunction

  function automatic void take_example(example_t ex);
    if (set_count < MAX_EXAMPLES_DEF) begin
      set_label[set_count]  = ex.label;
      set_weight[set_count] = ex.weight;
      set_count++;
      if (ex.label) begin
        set_pos_count++;
        set_pos_weight += ex.weight;
      end
    end
    if (ex.last) begin
      expected_stumps = {expected_stumps, search_stump()};
      set_count      = 0;
      set_pos_count  = 0;
      set_pos_weight = 0;
    end
  endfunction

  function automatic void push_example(logic lbl, logic [SAMPLE_W-1:0] w, logic last);
    example_t ex;
    ex.label  = lbl;
    ex.weight = w;
    ex.last   = last;
    pending_examples = {pending_examples, ex};
  endfunction

  function automatic void queue_set(int unsigned n, label_pattern_e lp, weight_pattern_e wp);
    logic        cur;
    int unsigned flip_at, span, i;
    logic [SAMPLE_W-1:0] w;
    cur     = 1'($urandom_range(0, 1));
    flip_at = $urandom_range(1, (n > 1) ? n - 1 : 1);
    span    = (n > 2) ? (131072 / n) : 65535;
    if (span > 65535) span = 65535;
    for (i = 0; i < n; i++) begin
      case (lp)
        LBL_RANDOM:     cur = 1'($urandom_range(0, 1));
        LBL_RUNS:       if (i > 0 && $urandom_range(0, 7) == 0) cur = !cur;
        LBL_ALTERNATE:  if (i > 0) cur = !cur;
        LBL_ONE_CHANGE: if (i == flip_at) cur = !cur;
        default:        ;
      endcase
      case (wp)
        WT_RANDOM:  w = SAMPLE_W'($urandom_range(0, 65535));
        WT_SMALL:   w = SAMPLE_W'($urandom_range(0, span));
        WT_EXTREME: w = $urandom_range(0, 1) ? {SAMPLE_W{1'b1}} : '0;
        default:    w = '0;
      endcase
      push_example(cur, w, i == n - 1);
    end
  endfunction

  function automatic label_pattern_e pick_label_pattern();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return LBL_RUNS;
    if (r < 60) return LBL_RANDOM;
    if (r < 75) return LBL_ONE_CHANGE;
    if (r < 85) return LBL_ALTERNATE;
    return LBL_CONSTANT;
  endfunction

  function automatic weight_pattern_e pick_weight_pattern();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return WT_SMALL;
    if (r < 75) return WT_RANDOM;
    if (r < 90) return WT_EXTREME;
    return WT_ZERO;
  endfunction

  // driver: a transfer happens at an edge where start is high and busy is low
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start          <= 1'b0;
      label_positive <= 1'b0;
      sample_weight  <= '0;
      last_example   <= 1'b0;
    end else begin
      if (start && !busy) begin
        take_example('{label: label_positive, weight: sample_weight, last: last_example});
        accepted_items++;
      end
      if (!start || !busy) begin
        if (accepted_items < total_items / 3) begin
          idle_pct = IDLE_PCT_FIRST;
        end else if (accepted_items < (2 * total_items) / 3) begin
          idle_pct = IDLE_PCT_SECOND;
        end else begin
          idle_pct = 0;
        end
        if (pending_examples.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          next_example = pending_examples.pop_front();
          start          <= 1'b1;
          label_positive <= next_example.label;
          sample_weight  <= next_example.weight;
          last_example   <= next_example.last;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: each strobe is one result transfer
  always @(posedge clk_i) begin
    if (rst_ni && result_valid) begin
      results_seen++;
      if (expected_stumps.size() == 0) begin
        report($sformatf("result %0d arrived with no set pending", results_seen));
      end else begin
        want = expected_stumps.pop_front();
        check_field("stump_found", stump_found, want.found);
        check_field("split_index", split_index, want.split);
        check_field("below_is_positive", below_is_positive, want.below_pos);
        check_field("mistake_count", mistake_count, want.mistakes);
        check_field("weighted_mistakes", weighted_mistakes, want.weighted);
      end
    end
  end

  initial begin
    set_count      = 0;
    set_pos_count  = 0;
    set_pos_weight = 0;
    accepted_items = 0;
    results_seen   = 0;
    mismatches     = 0;
    total_items    = 0;

    // single example, then minimal two-example sets
    push_example(1'b1, 16'hFFFF, 1'b1);
    push_example(1'b0, 16'h0000, 1'b0);
    push_example(1'b1, 16'hFFFF, 1'b1);
    push_example(1'b1, 16'hFFFF, 1'b0);
    push_example(1'b0, 16'h0000, 1'b1);
    // no label change
    push_example(1'b0, 16'h1234, 1'b0);
    push_example(1'b0, 16'hFFFF, 1'b0);
    push_example(1'b0, 16'h0000, 1'b1);
    // better later candidate blocked by weighted error of exactly one half
    push_example(1'b1, 16'h8000, 1'b0);
    push_example(1'b0, 16'h0100, 1'b0);
    push_example(1'b1, 16'h0001, 1'b0);
    push_example(1'b1, 16'h0002, 1'b0);
    push_example(1'b1, 16'h0003, 1'b1);
    // same, just below one half: replacement taken
    push_example(1'b1, 16'h7FFF, 1'b0);
    push_example(1'b0, 16'h0100, 1'b0);
    push_example(1'b1, 16'h0001, 1'b0);
    push_example(1'b1, 16'h0002, 1'b0);
    push_example(1'b1, 16'h0003, 1'b1);
    queue_set(6, LBL_ALTERNATE, WT_EXTREME);

    while (pending_examples.size() < ITEM_TARGET) begin
      if (pending_examples.size() >= 500 && pending_examples.size() < 500 + 60) begin
        // overfills the store; the tail examples are dropped
        queue_set(BIG_SET_SIZE, LBL_RUNS, WT_SMALL);
      end else begin
        case ($urandom_range(0, 19))
          0:       queue_set($urandom_range(65, 200), pick_label_pattern(),
                             pick_weight_pattern());
          1, 2, 3: queue_set($urandom_range(17, 64), pick_label_pattern(),
                             pick_weight_pattern());
          default: queue_set($urandom_range(1, 16), pick_label_pattern(),
                             pick_weight_pattern());
        endcase
      end
    end
    total_items = pending_examples.size();

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pending_examples.size() != 0 || start) @(posedge clk_i);
    while (expected_stumps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("** decision_stump_search: PASSED **");
    end else begin
      $display("** decision_stump_search: FAILED **");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF_NS);
    $display("timeout: %0d sets still expected", expected_stumps.size());
    $display("** decision_stump_search: FAILED **");
    $finish;
  end

endmodule
